/* hw/rtl/gf131_quartic_field_alu_core_defines.svh */
// Assertion macros for the GF(131^4) unit.
`ifndef GF131_QUARTIC_FIELD_ALU_CORE_DEFINES_SVH
`define GF131_QUARTIC_FIELD_ALU_CORE_DEFINES_SVH
// Implication checked on every edge outside reset.
`define GFQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gfq check failed");
// A plain invariant.
`define GFQ_ASSERT_ALW(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("gfq invariant failed");
`endif

/* hw/rtl/gfq_pkg.sv */
`default_nettype none
package gfq_pkg;
  localparam int unsigned Prime = 131;
  localparam int unsigned HalfOrder = 65;
  localparam int unsigned Depth = 8;
  // Register stages from the accepting edge to the edge that takes the result.
  localparam int Latency = 13;

  typedef logic [7:0] fe_t;
  typedef struct packed { fe_t re; fe_t im; } kel_t;
  typedef struct packed { kel_t lo; kel_t hi; } fel_t;
  typedef fe_t [Prime-1:0] inv_tab_t;
  typedef logic [Prime-1:0] leg_tab_t;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_SQR = 3'd3,
    CMD_NEG = 3'd4, CMD_INV = 3'd5, CMD_NRM = 3'd6, CMD_CHR = 3'd7
  } cmd_t;

  // Reduce a value below 2^16 mod 131. The quotient comes from a reciprocal
  // multiply: 64036 / 2^23 sits just above 1/131 and is exact for 16-bit values.
  function automatic fe_t md(input logic [15:0] v);
    logic [32:0] prod;
    logic [9:0] q;
    logic [16:0] r;
    begin
      prod = 33'(v) * 33'd64036;
      q = prod[32:23];
      r = 17'(v) - 17'(q) * 17'd131;
      md = r[7:0];
    end
  endfunction

  function automatic fe_t md8(input fe_t v);
    md8 = (v >= 8'd131) ? 8'(v - 8'd131) : v;
  endfunction

  function automatic fe_t fadd(input fe_t a, input fe_t b);
    logic [8:0] s;
    begin
      s = 9'(a) + 9'(b);
      fadd = (s >= 9'd131) ? 8'(s - 9'd131) : s[7:0];
    end
  endfunction

  function automatic fe_t fsub(input fe_t a, input fe_t b);
    fsub = (a >= b) ? 8'(a - b) : 8'(9'(a) + 9'd131 - 9'(b));
  endfunction

  function automatic fe_t fmul(input fe_t a, input fe_t b);
    fmul = md(16'(a) * 16'(b));
  endfunction

  function automatic kel_t kadd(input kel_t a, input kel_t b);
    kadd = '{fadd(a.re, b.re), fadd(a.im, b.im)};
  endfunction
  function automatic kel_t ksub(input kel_t a, input kel_t b);
    ksub = '{fsub(a.re, b.re), fsub(a.im, b.im)};
  endfunction
  function automatic kel_t ktwist(input kel_t a);
    ktwist = '{fsub(a.re, a.im), fadd(a.re, a.im)};
  endfunction

  function automatic fe_t pw(input fe_t b, input int unsigned e);
    fe_t r;
    fe_t q;
    int unsigned k;
    begin
      r = 8'd1;
      q = b;
      k = e;
      for (int unsigned n = 0; n < Depth; n++) begin
        if (k[0]) r = fmul(r, q);
        q = fmul(q, q);
        k = k >> 1;
      end
      pw = r;
    end
  endfunction

  function automatic fe_t inv_rom(input fe_t n);
    inv_rom = (n == 8'd0) ? 8'd0 : pw(n, Prime - 2);
  endfunction
  function automatic logic leg_rom(input fe_t n);
    leg_rom = (n != 8'd0) && (pw(n, HalfOrder) == 8'd1);
  endfunction

  function automatic inv_tab_t make_inv_tab();
    inv_tab_t t;
    for (int unsigned n = 0; n < Prime; n++) t[n] = inv_rom(8'(n));
    return t;
  endfunction
  function automatic leg_tab_t make_leg_tab();
    leg_tab_t t;
    for (int unsigned n = 0; n < Prime; n++) t[n] = leg_rom(8'(n));
    return t;
  endfunction

  // Constant lookup tables, built at elaboration.
  localparam inv_tab_t InvTab = make_inv_tab();
  localparam leg_tab_t LegTab = make_leg_tab();
endpackage
`default_nettype wire

/* hw/rtl/gf131_quartic_field_alu_core.sv */
`default_nettype none
// GF(131^4) arithmetic unit. A request is taken at every rising clock edge outside reset at
// which start is high; busy is tied low, so a new request may enter every cycle. Each request
// yields exactly one result on z_c0..z_c3, scalar and error, with done high for that one
// cycle: done and the result leave the output register together. The receiver cannot stall
// the unit, so nothing is ever held back and a valid bit travels with each request down
// thirteen register stages: input reduction, operand select, a K multiply, product combine,
// squares for the norm to F131, the table lookups, scaling of the conjugate norm, a second K
// multiply for the inverse, and the output register. Results of every command leave through
// the same output stage, so the latency never changes. Coefficients of 131..255 are first
// reduced mod 131. Inverse or character of zero sets error and returns zeros.
module gf131_quartic_field_alu_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] x_c0,
  input  wire logic [7:0] x_c1,
  input  wire logic [7:0] x_c2,
  input  wire logic [7:0] x_c3,
  input  wire logic [7:0] y_c0,
  input  wire logic [7:0] y_c1,
  input  wire logic [7:0] y_c2,
  input  wire logic [7:0] y_c3,
  output logic            done,
  output logic [7:0]      z_c0,
  output logic [7:0]      z_c1,
  output logic [7:0]      z_c2,
  output logic [7:0]      z_c3,
  output logic [7:0]      scalar,
  output logic            error
);
  import gfq_pkg::*;

  assign busy = 1'b0;

  // Valid bits along the pipe; bit 0 is set at the accepting edge and each bit feeds the next.
  logic [Latency-2:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Latency-3:0], start && !busy};
    end
  end

  // Stage 1: reduce inputs. Command and operand x then ride delay lines;
  // x is needed again by the inverse multipliers at stage 10.
  fel_t x_d [10];
  fel_t y1;
  cmd_t cmd_d [Latency-1];
  always_ff @(posedge clk) begin
    x_d[0] <= '{'{md8(x_c0), md8(x_c1)}, '{md8(x_c2), md8(x_c3)}};
    y1 <= '{'{md8(y_c0), md8(y_c1)}, '{md8(y_c2), md8(y_c3)}};
    cmd_d[0] <= cmd_t'(cmd);
    for (int k = 1; k < 10; k++) x_d[k] <= x_d[k-1];
    for (int k = 1; k < Latency-1; k++) cmd_d[k] <= cmd_d[k-1];
  end

  // Stage 2: operand select for the three multipliers, and the linear results
  // (add, sub, negate), which are then carried to the output stage.
  kel_t ma0, mb0, ma1, mb1, ma2, mb2;
  kel_t lin_d [Latency-2];
  kel_t linh_d [Latency-2];
  always_ff @(posedge clk) begin
    unique case (cmd_d[0])
      CMD_MUL: begin
        ma0 <= x_d[0].lo; mb0 <= y1.lo; ma1 <= x_d[0].hi; mb1 <= y1.hi;
        ma2 <= kadd(x_d[0].lo, x_d[0].hi); mb2 <= kadd(y1.lo, y1.hi);
      end
      default: begin
        ma0 <= x_d[0].lo; mb0 <= x_d[0].lo; ma1 <= x_d[0].hi; mb1 <= x_d[0].hi;
        ma2 <= x_d[0].lo; mb2 <= x_d[0].hi;
      end
    endcase
    unique case (cmd_d[0])
      CMD_ADD: begin
        lin_d[0] <= kadd(x_d[0].lo, y1.lo); linh_d[0] <= kadd(x_d[0].hi, y1.hi);
      end
      CMD_SUB: begin
        lin_d[0] <= ksub(x_d[0].lo, y1.lo); linh_d[0] <= ksub(x_d[0].hi, y1.hi);
      end
      default: begin
        lin_d[0] <= ksub('0, x_d[0].lo); linh_d[0] <= ksub('0, x_d[0].hi);
      end
    endcase
    for (int k = 1; k < Latency-2; k++) begin
      lin_d[k] <= lin_d[k-1];
      linh_d[k] <= linh_d[k-1];
    end
  end

  kel_t p0, p1, p2;
  gfq_kmul u_m0 (.clk(clk), .a(ma0), .b(mb0), .p(p0));
  gfq_kmul u_m1 (.clk(clk), .a(ma1), .b(mb1), .p(p1));
  gfq_kmul u_m2 (.clk(clk), .a(ma2), .b(mb2), .p(p2));
  // p* are aligned with cmd_d[3].

  // Stage 5: combine field products, and norm to K. The field product then
  // waits for the output stage.
  kel_t nk;
  kel_t fzl_d [8];
  kel_t fzh_d [8];
  always_ff @(posedge clk) begin
    nk <= ksub(p0, ktwist(p1));
    fzl_d[0] <= kadd(p0, ktwist(p1));
    unique case (cmd_d[3])
      CMD_MUL: fzh_d[0] <= ksub(ksub(p2, p0), p1);
      default: fzh_d[0] <= kadd(p2, p2);
    endcase
    for (int k = 1; k < 8; k++) begin
      fzl_d[k] <= fzl_d[k-1];
      fzh_d[k] <= fzh_d[k-1];
    end
  end
  // nk and fzl_d[0] are aligned with cmd_d[4].

  // Norm to F131: squares of nk (stages 6..7).
  logic [15:0] nrr, nii;
  fe_t nsum;
  kel_t nk_d6, nk_d7;
  always_ff @(posedge clk) begin
    nrr <= 16'(nk.re) * 16'(nk.re);
    nii <= 16'(nk.im) * 16'(nk.im);
    nk_d6 <= nk;
    nsum <= fadd(md(nrr), md(nii));
    nk_d7 <= nk_d6;
  end
  // nsum aligned with cmd_d[6].

  // Stage 8: table lookups. The norm, its character and its zero flag then
  // wait for the output stage.
  fe_t ninv;
  kel_t nk8;
  fe_t nv_d [5];
  logic nl_d [5];
  logic nz_d [5];
  always_ff @(posedge clk) begin
    ninv <= InvTab[nsum];
    nl_d[0] <= LegTab[nsum];
    nz_d[0] <= (nsum == 8'd0);
    nv_d[0] <= nsum;
    nk8 <= '{nk_d7.re, fsub(8'd0, nk_d7.im)};
    for (int k = 1; k < 5; k++) begin
      nv_d[k] <= nv_d[k-1];
      nl_d[k] <= nl_d[k-1];
      nz_d[k] <= nz_d[k-1];
    end
  end
  // aligned with cmd_d[7].

  // Stages 9..10: v = conj(nk) * ninv.
  logic [15:0] vr, vi;
  kel_t v;
  always_ff @(posedge clk) begin
    vr <= 16'(nk8.re) * 16'(ninv);
    vi <= 16'(nk8.im) * 16'(ninv);
    v <= '{md(vr), md(vi)};
  end
  // v aligned with cmd_d[9].

  kel_t ql, qh;
  gfq_kmul u_m3 (.clk(clk), .a(x_d[9].lo), .b(v), .p(ql));
  gfq_kmul u_m4 (.clk(clk), .a(x_d[9].hi), .b(v), .p(qh));
  // q, lin_d[10], fzl_d[7] and nv_d[4] are all aligned with cmd_d[11].

  // Stage 13: output register, fed by the result select below.
  logic [7:0] z_c0_next, z_c1_next, z_c2_next, z_c3_next, scalar_next;
  logic       error_next;
  always_comb begin
    z_c0_next = '0; z_c1_next = '0; z_c2_next = '0; z_c3_next = '0;
    scalar_next = '0; error_next = 1'b0;
    unique case (cmd_d[Latency-2])
      CMD_ADD, CMD_SUB, CMD_NEG: begin
        z_c0_next = lin_d[Latency-3].re; z_c1_next = lin_d[Latency-3].im;
        z_c2_next = linh_d[Latency-3].re; z_c3_next = linh_d[Latency-3].im;
      end
      CMD_MUL, CMD_SQR: begin
        z_c0_next = fzl_d[7].re; z_c1_next = fzl_d[7].im;
        z_c2_next = fzh_d[7].re; z_c3_next = fzh_d[7].im;
      end
      CMD_INV: begin
        if (nz_d[4]) begin
          error_next = 1'b1;
        end else begin
          z_c0_next = ql.re; z_c1_next = ql.im;
          z_c2_next = fsub(8'd0, qh.re); z_c3_next = fsub(8'd0, qh.im);
        end
      end
      CMD_NRM: scalar_next = nv_d[4];
      default: begin
        if (nz_d[4]) error_next = 1'b1;
        else scalar_next = nl_d[4] ? 8'd1 : 8'd130;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[Latency-2];
    end
    z_c0 <= z_c0_next;
    z_c1 <= z_c1_next;
    z_c2 <= z_c2_next;
    z_c3 <= z_c3_next;
    scalar <= scalar_next;
    error <= error_next;
  end
endmodule
`default_nettype wire

/* hw/rtl/gfq_kmul.sv */
`default_nettype none
// Registered multiply in K = F131[i]: the partial products are registered, then the reduced result.
module gfq_kmul (
  input  wire logic         clk,
  input  wire gfq_pkg::kel_t a,
  input  wire gfq_pkg::kel_t b,
  output gfq_pkg::kel_t     p
);
  import gfq_pkg::*;
  logic [15:0] rr, ii, ri, ir;
  always_ff @(posedge clk) begin
    rr <= 16'(a.re) * 16'(b.re);
    ii <= 16'(a.im) * 16'(b.im);
    ri <= 16'(a.re) * 16'(b.im);
    ir <= 16'(a.im) * 16'(b.re);
  end
  always_ff @(posedge clk) begin
    p <= '{fsub(md(rr), md(ii)), fadd(md(ri), md(ir))};
  end
endmodule
`default_nettype wire

/* hw/rtl/gfq_checker.sv */
`default_nettype none
`include "gf131_quartic_field_alu_core_defines.svh"
module gfq_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] cmd,
  input wire logic       done,
  input wire logic [7:0] z_c0,
  input wire logic [7:0] z_c1,
  input wire logic [7:0] z_c2,
  input wire logic [7:0] z_c3,
  input wire logic [7:0] scalar,
  input wire logic       error
);
  import gfq_pkg::*;
  `GFQ_ASSERT_IMP(a_done_lat, $past(start && !busy, Latency) && !$past(rst, Latency), done)
  `GFQ_ASSERT_IMP(a_err_zero, done && error,
                  z_c0 == 8'd0 && z_c1 == 8'd0 && z_c2 == 8'd0 && z_c3 == 8'd0 &&
                  scalar == 8'd0)
  `GFQ_ASSERT_IMP(a_range, done, z_c0 < 8'd131 && z_c1 < 8'd131 && z_c2 < 8'd131 &&
                  z_c3 < 8'd131 && scalar < 8'd131)
  `GFQ_ASSERT_IMP(a_err_cmd, done && error,
                  $past(cmd, Latency) == CMD_INV || $past(cmd, Latency) == CMD_CHR)
  `GFQ_ASSERT_ALW(a_nobusy, !busy)
endmodule
bind gf131_quartic_field_alu_core gfq_checker u_chk (.*);
`default_nettype wire
